// File: rtl/core/rmq_pkg.sv
// Package for the rotation matrix to quaternion block: widths, lane codes and
// pipeline depths shared by the core. Depends on nothing.
package rmq_pkg;

  // Fraction bits of the input and output fixed-point fields.
  localparam int FRAC_BITS = 16;

  // Width of one matrix element and of one quaternion component.
  localparam int FW = 18;
  // Width of an off-diagonal sum or difference.
  localparam int DW = FW + 1;
  // Signed width of t = 1 +/- m00 +/- m11 +/- m22.
  localparam int TW = ((FRAC_BITS > FW - 1) ? FRAC_BITS : FW - 1) + 3;
  // Root bits: the radicand T * 2^F has at most TW - 1 + F bits.
  localparam int SQ = (TW + FRAC_BITS) / 2;
  // Radicand width, padded to an even count.
  localparam int NW = 2 * SQ;
  // Partial remainder width inside the square root.
  localparam int RW = SQ + 3;
  // Quotient bits kept below the saturation threshold 2^(FW-1).
  localparam int QB = FW - 1;
  // Dividend width (|d| * 2^F) and the working width of the divider.
  localparam int AW = DW + FRAC_BITS;
  localparam int CW = ((AW > SQ + 1 + QB) ? AW : SQ + 1 + QB) + 1;

  // Output limits.
  localparam logic signed [FW-1:0] OUT_MAX = {1'b0, {(FW-1){1'b1}}};
  localparam logic signed [FW-1:0] OUT_MIN = {1'b1, {(FW-1){1'b0}}};

  // Raw value of 1.0.
  localparam logic [TW-1:0] ONE = TW'(64'd1 << FRAC_BITS);

  // Quaternion lane codes.
  localparam logic [1:0] Q_W = 2'd0;
  localparam logic [1:0] Q_X = 2'd1;
  localparam logic [1:0] Q_Y = 2'd2;
  localparam logic [1:0] Q_Z = 2'd3;

  // Side data that travels with an item through the arithmetic stages.
  typedef struct packed {
    logic                         degen;
    logic [1:0]                   diag;
    logic signed [3:0][DW-1:0]    d;
  } side_t;

endpackage

// File: rtl/core/rotation_matrix_to_quaternion.sv
// Top level of the rotation matrix to quaternion converter: case selection,
// pipelined square root and four pipelined dividers. Depends on rmq_pkg.
//
// The block takes one 3x3 rotation matrix per beat and returns one quaternion
// per beat, with a throughput of one matrix per clock cycle while the output
// is not held by back pressure. The selection register loads at the
// accepting edge, followed by the radicand register, one stage per root bit
// of the square root, one stage for the saturation compare, one stage per
// quotient bit of the four parallel dividers, and the output register. All
// stages advance together while the output register is empty or being taken,
// so input ready follows output ready combinationally. The degenerate flag
// marks a non-positive t; the four components are then zero.
module rotation_matrix_to_quaternion (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (18 bits each), 6 zero bits
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // q_w, q_x, q_y, q_z (18 bits each)
  output logic [71:0]  m_axis_tdata,
  // degenerate
  output logic [0:0]   m_axis_tuser
);

  localparam int FW = rmq_pkg::FW;
  localparam int DW = rmq_pkg::DW;
  localparam int TW = rmq_pkg::TW;
  localparam int SQ = rmq_pkg::SQ;
  localparam int NW = rmq_pkg::NW;
  localparam int RW = rmq_pkg::RW;
  localparam int QB = rmq_pkg::QB;
  localparam int CW = rmq_pkg::CW;
  localparam int F  = rmq_pkg::FRAC_BITS;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Case selection on the incoming beat.
  logic signed [FW-1:0] m [9];
  logic signed [DW-1:0] sum0011;
  logic signed [TW-1:0] t_c;
  rmq_pkg::side_t       side_c;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m[i] = $signed(s_axis_tdata[i*FW +: FW]);
    end
    sum0011 = DW'(m[0]) + DW'(m[4]);
    side_c.degen = 1'b0;
    side_c.d = '0;
    if (m[8] < 0) begin
      if (m[0] > m[4]) begin
        t_c = $signed(rmq_pkg::ONE) + TW'(m[0]) - TW'(m[4]) - TW'(m[8]);
        side_c.diag = rmq_pkg::Q_X;
        side_c.d[0] = DW'(m[5]) - DW'(m[7]);
        side_c.d[2] = DW'(m[1]) + DW'(m[3]);
        side_c.d[3] = DW'(m[6]) + DW'(m[2]);
      end else begin
        t_c = $signed(rmq_pkg::ONE) - TW'(m[0]) + TW'(m[4]) - TW'(m[8]);
        side_c.diag = rmq_pkg::Q_Y;
        side_c.d[0] = DW'(m[6]) - DW'(m[2]);
        side_c.d[1] = DW'(m[1]) + DW'(m[3]);
        side_c.d[3] = DW'(m[5]) + DW'(m[7]);
      end
    end else begin
      if (sum0011 < 0) begin
        t_c = $signed(rmq_pkg::ONE) - TW'(m[0]) - TW'(m[4]) + TW'(m[8]);
        side_c.diag = rmq_pkg::Q_Z;
        side_c.d[0] = DW'(m[1]) - DW'(m[3]);
        side_c.d[1] = DW'(m[6]) + DW'(m[2]);
        side_c.d[2] = DW'(m[5]) + DW'(m[7]);
      end else begin
        t_c = $signed(rmq_pkg::ONE) + TW'(m[0]) + TW'(m[4]) + TW'(m[8]);
        side_c.diag = rmq_pkg::Q_W;
        side_c.d[1] = DW'(m[5]) - DW'(m[7]);
        side_c.d[2] = DW'(m[6]) - DW'(m[2]);
        side_c.d[3] = DW'(m[1]) - DW'(m[3]);
      end
    end
  end

  // Selection register.
  logic                 a_valid;
  logic signed [TW-1:0] a_t;
  rmq_pkg::side_t       a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_axis_tvalid;
    end
    if (en) begin
      a_t    <= t_c;
      a_side <= side_c;
    end
  end

  // Square root, one root bit per stage.
  logic                 sq_valid [SQ+1];
  logic [RW-1:0]        sq_rem   [SQ+1];
  logic [SQ-1:0]        sq_root  [SQ+1];
  logic [NW-1:0]        sq_n     [SQ+1];
  rmq_pkg::side_t       sq_side  [SQ+1];
  logic [RW-1:0]        sq_rem_next  [SQ];
  logic [SQ-1:0]        sq_root_next [SQ];
  logic [RW-1:0]        sq_shift [SQ];
  logic [RW-1:0]        sq_trial [SQ];
  logic                 a_degen;
  rmq_pkg::side_t       a_side_d;

  assign a_degen = (a_t <= 0);

  // Side data with the degenerate flag filled in.
  always_comb begin
    a_side_d       = a_side;
    a_side_d.degen = a_degen;
  end

  always_comb begin
    for (int k = 0; k < SQ; k++) begin
      sq_shift[k] = {sq_rem[k][RW-3:0], sq_n[k][NW-1 -: 2]};
      sq_trial[k] = RW'({sq_root[k], 2'b01});
      if (sq_shift[k] >= sq_trial[k]) begin
        sq_rem_next[k]  = sq_shift[k] - sq_trial[k];
        sq_root_next[k] = {sq_root[k][SQ-2:0], 1'b1};
      end else begin
        sq_rem_next[k]  = sq_shift[k];
        sq_root_next[k] = {sq_root[k][SQ-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQ; k++) begin
        sq_valid[k] <= 1'b0;
      end
    end else if (en) begin
      sq_valid[0] <= a_valid;
      for (int k = 0; k < SQ; k++) begin
        sq_valid[k+1] <= sq_valid[k];
      end
    end
    if (en) begin
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_n[0]    <= a_degen ? '0 : (NW'(unsigned'(a_t)) << F);
      sq_side[0] <= a_side_d;
      for (int k = 0; k < SQ; k++) begin
        sq_rem[k+1]  <= sq_rem_next[k];
        sq_root[k+1] <= sq_root_next[k];
        sq_n[k+1]    <= {sq_n[k][NW-3:0], 2'b00};
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // Divider front: magnitudes and the saturation compare against 2r * 2^QB.
  logic [SQ:0]    den_c;
  logic [DW-1:0]  mag_c [4];
  logic [CW-1:0]  num_c [4];
  logic           sat_c [4];

  always_comb begin
    den_c = {sq_root[SQ], 1'b0};
    for (int i = 0; i < 4; i++) begin
      mag_c[i] = ($signed(sq_side[SQ].d[i]) < 0) ? unsigned'(-sq_side[SQ].d[i])
                                                 : unsigned'(sq_side[SQ].d[i]);
      num_c[i] = CW'(mag_c[i]) << F;
      sat_c[i] = num_c[i] >= (CW'(den_c) << QB);
    end
  end

  // Restoring dividers, one quotient bit per stage in each of four lanes.
  logic           dv_valid [QB+1];
  logic [SQ:0]    dv_den   [QB+1];
  logic [SQ-1:0]  dv_root  [QB+1];
  rmq_pkg::side_t dv_side  [QB+1];
  logic [CW-1:0]  dv_rem   [QB+1][4];
  logic [QB-1:0]  dv_q     [QB+1][4];
  logic           dv_sat   [QB+1][4];
  logic [CW-1:0]  dv_rem_next [QB][4];
  logic [QB-1:0]  dv_q_next   [QB][4];
  logic [CW-1:0]  dv_sub      [QB][4];

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      for (int i = 0; i < 4; i++) begin
        dv_sub[k][i] = CW'(dv_den[k]) << (QB - 1 - k);
        if (dv_rem[k][i] >= dv_sub[k][i]) begin
          dv_rem_next[k][i] = dv_rem[k][i] - dv_sub[k][i];
          dv_q_next[k][i]   = {dv_q[k][i][QB-2:0], 1'b1};
        end else begin
          dv_rem_next[k][i] = dv_rem[k][i];
          dv_q_next[k][i]   = {dv_q[k][i][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) begin
        dv_valid[k] <= 1'b0;
      end
    end else if (en) begin
      dv_valid[0] <= sq_valid[SQ];
      for (int k = 0; k < QB; k++) begin
        dv_valid[k+1] <= dv_valid[k];
      end
    end
    if (en) begin
      dv_den[0]  <= den_c;
      dv_root[0] <= sq_root[SQ];
      dv_side[0] <= sq_side[SQ];
      for (int i = 0; i < 4; i++) begin
        dv_rem[0][i] <= num_c[i];
        dv_q[0][i]   <= '0;
        dv_sat[0][i] <= sat_c[i];
      end
      for (int k = 0; k < QB; k++) begin
        dv_den[k+1]  <= dv_den[k];
        dv_root[k+1] <= dv_root[k];
        dv_side[k+1] <= dv_side[k];
        for (int i = 0; i < 4; i++) begin
          dv_rem[k+1][i] <= dv_rem_next[k][i];
          dv_q[k+1][i]   <= dv_q_next[k][i];
          dv_sat[k+1][i] <= dv_sat[k][i];
        end
      end
    end
  end

  // Component selection, sign and saturation.
  logic [SQ-1:0]        half_root;
  logic signed [FW-1:0] comp_c [4];
  logic [71:0]          tdata_c;

  always_comb begin
    half_root = dv_root[QB] >> 1;
    for (int i = 0; i < 4; i++) begin
      if (dv_side[QB].degen) begin
        comp_c[i] = '0;
      end else if (dv_side[QB].diag == 2'(i)) begin
        comp_c[i] = (half_root > SQ'(rmq_pkg::OUT_MAX)) ? rmq_pkg::OUT_MAX
                                                        : FW'(half_root);
      end else if (dv_sat[QB][i]) begin
        comp_c[i] = ($signed(dv_side[QB].d[i]) < 0) ? rmq_pkg::OUT_MIN
                                                    : rmq_pkg::OUT_MAX;
      end else if ($signed(dv_side[QB].d[i]) < 0) begin
        comp_c[i] = -$signed(FW'(dv_q[QB][i]));
      end else begin
        comp_c[i] = $signed(FW'(dv_q[QB][i]));
      end
      tdata_c[i*FW +: FW] = comp_c[i];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_valid[QB];
    end
    if (en) begin
      m_axis_tdata <= tdata_c;
      m_axis_tuser <= dv_side[QB].degen;
    end
  end

`ifndef SYNTH
  // A degenerate result carries all-zero components.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("degenerate beat with nonzero components");

  // A positive t always gives a nonzero root.
  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    sq_valid[SQ] && !sq_side[SQ].degen |-> sq_root[SQ] != '0)
    else $error("zero root for positive t");

  // While the output stalls, the divider pipeline holds its items.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv_valid[QB]) && $stable(dv_q[QB][0]))
    else $error("pipeline moved during stall");
`endif

endmodule

// File: tb/sv/rmq_checker.sv
// Checker for the rotation matrix to quaternion block: watches both stream
// channels, predicts each quaternion and compares it. Depends on rmq_pkg.
module rmq_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [71:0]  m_axis_tdata,
  input  logic [0:0]   m_axis_tuser,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic          degen;
    logic [71:0]   quat;
  } quat_t;

  quat_t quat_fifo[$];

  // Integer square root, rounded down.
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clamp18(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  // Off-diagonal component: (d * 2^F) / den, truncated toward zero.
  function automatic longint off_diag(longint d, longint unsigned den);
    longint unsigned mag;
    longint q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = longint'((mag << rmq_pkg::FRAC_BITS) / den);
    return (d < 0) ? -q : q;
  endfunction

  function automatic quat_t predict_quat(logic [167:0] data);
    longint m [9];
    longint d [4];
    longint q [4];
    longint t;
    longint unsigned r;
    int diag;
    quat_t res;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(data[i*18 +: 18]));
    d = '{0, 0, 0, 0};
    q = '{0, 0, 0, 0};
    if (m[8] < 0) begin
      if (m[0] > m[4]) begin
        t = 65536 + m[0] - m[4] - m[8]; diag = rmq_pkg::Q_X;
        d[0] = m[5] - m[7]; d[2] = m[1] + m[3]; d[3] = m[6] + m[2];
      end else begin
        t = 65536 - m[0] + m[4] - m[8]; diag = rmq_pkg::Q_Y;
        d[0] = m[6] - m[2]; d[1] = m[1] + m[3]; d[3] = m[5] + m[7];
      end
    end else if (m[0] < -m[4]) begin
      t = 65536 - m[0] - m[4] + m[8]; diag = rmq_pkg::Q_Z;
      d[0] = m[1] - m[3]; d[1] = m[6] + m[2]; d[2] = m[5] + m[7];
    end else begin
      t = 65536 + m[0] + m[4] + m[8]; diag = rmq_pkg::Q_W;
      d[1] = m[5] - m[7]; d[2] = m[6] - m[2]; d[3] = m[1] - m[3];
    end
    res.degen = (t <= 0);
    if (t > 0) begin
      r = root_floor(longint'(t) << rmq_pkg::FRAC_BITS);
      for (int i = 0; i < 4; i++)
        q[i] = (i == diag) ? clamp18(longint'(r >> 1)) : clamp18(off_diag(d[i], r << 1));
    end
    for (int i = 0; i < 4; i++) res.quat[i*18 +: 18] = q[i][17:0];
    return res;
  endfunction

  // Predict on every accepted input beat, compare on every output beat.
  always @(posedge clk) begin
    quat_t exp_q;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) quat_fifo.push_back(predict_quat(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (quat_fifo.size() == 0) begin
          $display("%0t: unexpected beat, actual q=%h degen=%b", $time, m_axis_tdata,
                   m_axis_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_q = quat_fifo.pop_front();
          if (exp_q.quat !== m_axis_tdata || exp_q.degen !== m_axis_tuser[0]) begin
            $display("%0t: mismatch, expected q=%h degen=%b, actual q=%h degen=%b", $time,
                     exp_q.quat, exp_q.degen, m_axis_tdata, m_axis_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    // Count of quaternions still owed by the block.
    pending <= quat_fifo.size();
  end
endmodule

// File: tb/sv/tb_rotation_matrix_to_quaternion.sv
// Testbench top for rotation_matrix_to_quaternion: drives matrices with random
// gaps and back pressure, gives the verdict. Depends on it and rmq_checker.
module tb_rotation_matrix_to_quaternion;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [71:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  int           fail_count;
  int           pending;
  bit           stim_done = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  rotation_matrix_to_quaternion i_dut (.*);

  rmq_checker i_checker (.*);

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [17:0] rand_elem();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 18'h1FFFF;
    if (p == 1) return 18'h20000;
    if (p < 5) return 18'($urandom_range(0, 131072) - 65536);
    return 18'($urandom);
  endfunction

  // Rotation about one axis with a random angle, so all cases show up.
  function automatic logic [167:0] rand_rotation();
    real a, c, s;
    logic [167:0] v;
    int e [9];
    a = $urandom_range(0, 62831) / 10000.0;
    c = $cos(a) * 65536.0;
    s = $sin(a) * 65536.0;
    case ($urandom_range(0, 2))
      0: e = '{65536, 0, 0, 0, int'(c), -int'(s), 0, int'(s), int'(c)};
      1: e = '{int'(c), 0, int'(s), 0, 65536, 0, -int'(s), 0, int'(c)};
      default: e = '{int'(c), -int'(s), 0, int'(s), int'(c), 0, 0, 0, 65536};
    endcase
    if ($urandom_range(0, 1)) begin
      // Flip two axes: still a rotation, moves the large diagonal term.
      e[0] = -e[0]; e[1] = -e[1]; e[2] = -e[2];
      e[3] = -e[3]; e[4] = -e[4]; e[5] = -e[5];
    end
    v = '0;
    for (int i = 0; i < 9; i++) v[i*18 +: 18] = 18'(e[i] + $urandom_range(0, 7) - 3);
    return v;
  endfunction

  // Valid stays high after the accepting edge; the next call or the caller
  // drops it, so back-to-back beats need no extra edge.
  task automatic send_beat(logic [167:0] data);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_axis_tdata  <= data;
    s_axis_tvalid <= 1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_diag(int a, int b, int c);
    logic [167:0] v;
    v = '0;
    v[0 +: 18] = 18'(a); v[72 +: 18] = 18'(b); v[144 +: 18] = 18'(c);
    for (int i = 1; i < 8; i++)
      if (i != 4) v[i*18 +: 18] = rand_elem();
    send_beat(v);
  endtask

  // Receiver back pressure.
  initial begin
    @(negedge rst);
    forever begin
      int g;
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin
    logic [167:0] v;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: identity diagonal, each diagonal case, extremes.
    send_diag(65536, 65536, 65536);
    send_diag(65536, -65536, -65536);
    send_diag(-65536, 65536, -65536);
    send_diag(-65536, -65536, 65536);
    send_diag(0, 0, -65536);
    send_diag(-131072, -131072, -131072);
    send_diag(131071, 131071, 131071);
    send_diag(-131072, 131071, -1);
    send_diag(131071, -131072, 0);
    send_diag(-131072, -131072, 0);
    send_diag(-65536, 0, 0);
    send_diag(1, 1, -131072);
    send_diag(5, 5, -1);
    v = {168{1'b1}}; v[167:162] = '0; send_beat(v);
    v = '0; send_beat(v);
    for (int i = 0; i < 9; i++) v[i*18 +: 18] = (i % 2) ? 18'h1FFFF : 18'h20000;
    send_beat(v);
    for (int i = 0; i < 9; i++) v[i*18 +: 18] = (i % 2) ? 18'h20000 : 18'h1FFFF;
    send_beat(v);
    for (int k = 0; k < 4; k++) send_beat(rand_rotation());
    // Hold off until the pipe has drained.
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 1030; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        v = '0;
        for (int i = 0; i < 9; i++) v[i*18 +: 18] = rand_elem();
        send_beat(v);
      end else begin
        send_beat(rand_rotation());
      end
    end
    s_axis_tvalid <= 0;
    stim_done = 1;
  end

  // Wait for the last quaternion, then judge.
  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// File: rotation_matrix_to_quaternion.f
rtl/core/rmq_pkg.sv
rtl/core/rotation_matrix_to_quaternion.sv
tb/sv/rmq_checker.sv
tb/sv/tb_rotation_matrix_to_quaternion.sv
